[rtl/adc_to_position_inverse_interp_assert.svh]
// Assertion macros for the ADC-to-position linearizer.
`ifndef ADC_TO_POSITION_INVERSE_INTERP_ASSERT_SVH
`define ADC_TO_POSITION_INVERSE_INTERP_ASSERT_SVH

// Same-cycle implication.
`define ATP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define ATP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/atp_pkg.sv]
// Shared constants, types and calibration ROM for the ADC-to-position linearizer.
package atp_pkg;

  localparam int BREAKPOINTS_DEF = 53;
  localparam int FRAC_BITS_DEF   = 10;
  localparam int ADC_BITS_DEF    = 12;

  localparam int OUT_W     = 16;
  localparam int ROM_W     = 12;
  localparam int ROM_DEPTH = 64;
  localparam int ROM_IDX_W = 6;
  localparam int Q_DEPTH   = 2;  // power of two

  typedef enum logic [1:0] {
    KIND_SEG,
    KIND_TOP,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // ADC code read at each millimetre; padded flat at full scale
  localparam logic [ROM_W-1:0] CAL_ROM [ROM_DEPTH] = '{
    12'd0,    12'd0,    12'd0,    12'd0,    12'd30,   12'd98,   12'd216,  12'd302,
    12'd352,  12'd419,  12'd488,  12'd590,  12'd654,  12'd748,  12'd834,  12'd893,
    12'd970,  12'd1053, 12'd1152, 12'd1232, 12'd1292, 12'd1388, 12'd1472, 12'd1589,
    12'd1644, 12'd1718, 12'd1802, 12'd1888, 12'd1956, 12'd2050, 12'd2126, 12'd2218,
    12'd2277, 12'd2374, 12'd2453, 12'd2521, 12'd2615, 12'd2725, 12'd2795, 12'd2872,
    12'd2950, 12'd3030, 12'd3133, 12'd3238, 12'd3337, 12'd3485, 12'd3600, 12'd3723,
    12'd3843, 12'd4000, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095
  };

  // index of the last distinct breakpoint among the first n entries
  function automatic int top_index(int n);
    int t;
    t = 0;
    for (int j = 1; j < n; j++) begin
      if (CAL_ROM[j] > CAL_ROM[j-1]) t = j;
    end
    return t;
  endfunction

endpackage

[rtl/atp_front.sv]
// Front end: finds the calibration segment for an incoming ADC code.
module atp_front import atp_pkg::*; #(
  parameter int BREAKPOINTS = BREAKPOINTS_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic [ADC_BITS-1:0]            code_i,
  output logic [$clog2(BREAKPOINTS)-1:0] seg_o,
  output kind_e                          kind_o
);

  localparam int SEG_W = $clog2(BREAKPOINTS);
  localparam int CMP_W = (ADC_BITS > ROM_W) ? ADC_BITS : ROM_W;
  localparam int TOP   = top_index(BREAKPOINTS);

  logic [CMP_W-1:0] code_w;
  logic             found;

  always_comb begin
    code_w = CMP_W'(code_i);
    seg_o  = '0;
    found  = 1'b0;
    // highest rising segment whose lower breakpoint is at or below the code
    for (int j = 0; j < BREAKPOINTS - 1; j++) begin
      if ((CMP_W'(CAL_ROM[j]) <= code_w) && (CAL_ROM[j+1] > CAL_ROM[j])) begin
        seg_o = SEG_W'(j);
        found = 1'b1;
      end
    end
    if (code_w >= CMP_W'(CAL_ROM[TOP])) begin
      kind_o = KIND_TOP;
    end else if (found) begin
      kind_o = KIND_SEG;
    end else begin
      kind_o = KIND_NONE;
    end
  end

endmodule

[rtl/atp_queue.sv]
// Short request queue between the classifier and the divider pipeline.
module atp_queue import atp_pkg::*; #(
  parameter int BREAKPOINTS = BREAKPOINTS_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [ADC_BITS-1:0]            code_i,
  input  logic [$clog2(BREAKPOINTS)-1:0] seg_i,
  input  kind_e                          kind_i,
  input  logic                           pop_i,
  output logic [ADC_BITS-1:0]            code_o,
  output logic [$clog2(BREAKPOINTS)-1:0] seg_o,
  output kind_e                          kind_o,
  output q_status_t                      status_o
);

  localparam int SEG_W  = $clog2(BREAKPOINTS);
  localparam int KIND_W = $bits(kind_e);
  localparam int EW     = KIND_W + SEG_W + ADC_BITS;
  localparam int PTR_W  = $clog2(Q_DEPTH);
  localparam int CNT_W  = $clog2(Q_DEPTH + 1);

  logic [EW-1:0]    entry_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [EW-1:0]    head;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= {kind_i, seg_i, code_i};
    end
  end

  assign head            = entry_q[rd_ptr_q];
  assign code_o          = head[ADC_BITS-1:0];
  assign seg_o           = head[ADC_BITS +: SEG_W];
  assign kind_o          = kind_e'(head[EW-1 -: KIND_W]);
  assign status_o.full   = (count_q == CNT_W'(Q_DEPTH));
  assign status_o.empty  = (count_q == '0);

endmodule

[rtl/atp_back.sv]
// Back end: breakpoint lookup, pipelined restoring divider and result register.
module atp_back import atp_pkg::*; #(
  parameter int BREAKPOINTS = BREAKPOINTS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [ADC_BITS-1:0]            code_i,
  input  logic [$clog2(BREAKPOINTS)-1:0] seg_i,
  input  kind_e                          kind_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [OUT_W-1:0]               position_o
);

  localparam int SEG_W  = $clog2(BREAKPOINTS);
  localparam int TOP    = top_index(BREAKPOINTS);
  localparam int RES_W  = SEG_W + FRAC_BITS;
  localparam int WIDE_W = (RES_W > OUT_W) ? RES_W : OUT_W;

  logic                 adv;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_pos_q;
  logic [FRAC_BITS:0]   s_v_q;
  kind_e                s_kind_q [FRAC_BITS+1];
  logic [SEG_W-1:0]     s_seg_q  [FRAC_BITS+1];
  logic [ROM_W-1:0]     s_den_q  [FRAC_BITS+1];
  logic [ROM_W-1:0]     s_rem_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] s_quo_q  [FRAC_BITS+1];
  logic [ROM_W-1:0]     bp_lo, bp_hi;
  logic [WIDE_W-1:0]    res_wide;
  logic [OUT_W-1:0]     pos_d;

  // whole pipeline moves unless a finished result is held
  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && valid_i;

  assign bp_lo = CAL_ROM[ROM_IDX_W'(seg_i)];
  assign bp_hi = CAL_ROM[ROM_IDX_W'(seg_i) + ROM_IDX_W'(1)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s_v_q       <= {s_v_q[FRAC_BITS-1:0], valid_i};
      out_valid_q <= s_v_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_kind_q[0] <= kind_i;
      s_seg_q[0]  <= seg_i;
      s_den_q[0]  <= bp_hi - bp_lo;
      s_rem_q[0]  <= ROM_W'(code_i) - bp_lo;
      s_quo_q[0]  <= '0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [ROM_W:0]   trial;
    logic             ge;
    logic [ROM_W-1:0] rem_n;

    always_comb begin
      trial = {s_rem_q[i], 1'b0};
      ge    = (trial >= {1'b0, s_den_q[i]});
      rem_n = ge ? ROM_W'(trial - {1'b0, s_den_q[i]}) : ROM_W'(trial);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_kind_q[i+1] <= s_kind_q[i];
        s_seg_q[i+1]  <= s_seg_q[i];
        s_den_q[i+1]  <= s_den_q[i];
        s_rem_q[i+1]  <= rem_n;
        s_quo_q[i+1]  <= {s_quo_q[i][FRAC_BITS-2:0], ge};
      end
    end
  end

  always_comb begin
    case (s_kind_q[FRAC_BITS])
      KIND_SEG: res_wide = WIDE_W'({s_seg_q[FRAC_BITS], s_quo_q[FRAC_BITS]});
      KIND_TOP: res_wide = WIDE_W'(TOP) << FRAC_BITS;
      default:  res_wide = '0;
    endcase
    if (res_wide > WIDE_W'({OUT_W{1'b1}})) begin
      pos_d = {OUT_W{1'b1}};
    end else begin
      pos_d = res_wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pos_q <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;

endmodule

[rtl/adc_to_position_inverse_interp.sv]
// Throughput: one request per cycle unless a held result stalls the pipeline;
//   set by the FRAC_BITS-stage divider pipeline, one quotient bit per stage,
//   fed from a two-entry request queue.
// Reset (rst_ni, async, active low) empties the queue and the pipeline valids;
//   the block has no configuration and no stored state beyond in-flight requests.
`include "adc_to_position_inverse_interp_assert.svh"

module adc_to_position_inverse_interp import atp_pkg::*; #(
  parameter int BREAKPOINTS = BREAKPOINTS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ADC_BITS-1:0] adc_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_W-1:0]    position_q_o
);

  localparam int SEG_W = $clog2(BREAKPOINTS);

  logic [SEG_W-1:0]    f_seg;
  kind_e               f_kind;
  logic                in_accept;
  logic                q_pop;
  q_status_t           q_stat;
  logic [ADC_BITS-1:0] q_code;
  logic [SEG_W-1:0]    q_seg;
  kind_e               q_kind;

  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i && !q_stat.full;

  atp_front #(
    .BREAKPOINTS (BREAKPOINTS),
    .ADC_BITS    (ADC_BITS)
  ) u_front (
    .code_i (adc_code_i),
    .seg_o  (f_seg),
    .kind_o (f_kind)
  );

  atp_queue #(
    .BREAKPOINTS (BREAKPOINTS),
    .ADC_BITS    (ADC_BITS)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_accept),
    .code_i   (adc_code_i),
    .seg_i    (f_seg),
    .kind_i   (f_kind),
    .pop_i    (q_pop),
    .code_o   (q_code),
    .seg_o    (q_seg),
    .kind_o   (q_kind),
    .status_o (q_stat)
  );

  atp_back #(
    .BREAKPOINTS (BREAKPOINTS),
    .FRAC_BITS   (FRAC_BITS),
    .ADC_BITS    (ADC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!q_stat.empty),
    .code_i      (q_code),
    .seg_i       (q_seg),
    .kind_i      (q_kind),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_q_o)
  );

  `ATP_ASSERT_IMP(a_q_full_xor_empty, clk_i, rst_ni, 1'b1, !(q_stat.full && q_stat.empty))
  `ATP_ASSERT_NXT(a_push_lands, clk_i, rst_ni, in_accept, !q_stat.empty)
  `ATP_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, q_pop, !q_stat.empty)
  `ATP_ASSERT_IMP(a_no_pop_held, clk_i, rst_ni, out_valid_o && out_stall_i, !q_pop)

endmodule
